// ----- src/cphtk_pkg.sv -----
// ----------------------------------------------------------------------------
// cphtk_pkg
// Shared types, codes and constants of the cubic-probe account table.
// ----------------------------------------------------------------------------
`default_nettype none

package cphtk_pkg;

   localparam int HASH_MOD    = 100003;
   localparam int MAX_ENTRIES = 8191;
   localparam int CNT_W       = 13;
   localparam int POW_N       = 21;
   localparam int RED_W       = 25;
   localparam int MOD_W       = 21;
   localparam int SHIFT_TOP   = 24;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_LOOKUP = 3'd1;
   localparam logic [2:0] KIND_ADD    = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_TOPK   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [63:0]        key_bytes_0_7;
      logic [63:0]        key_bytes_8_15;
      logic [47:0]        key_bytes_16_21;
      logic signed [31:0] amount;
      logic [6:0]         top_k_count;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic signed [31:0] balance;
      logic [12:0]        entry_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        key0;
      logic [63:0]        key1;
      logic [47:0]        key2;
      logic signed [31:0] bal;
   } slot_type;

   typedef logic [16:0] pow_tab_type [0:POW_N-1];

   typedef enum logic [2:0] {
      H_IDLE,
      H_MUL,
      H_RED,
      H_ACC,
      H_FMAG,
      H_DONE
   } hash_state_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_HASH,
      S_PROBE,
      S_DECIDE,
      S_LREM_RD,
      S_LREM_CHK,
      S_LADD_RD,
      S_LADD_CHK,
      S_TK_RD,
      S_TK_GET,
      S_RESP
   } state_type;

   function automatic pow_tab_type pow37_table();
      pow_tab_type t;
      logic [33:0] r;
      r = 34'd1;
      for (int p = 0; p < POW_N; p++) begin
         t[p] = r[16:0];
         r = (r * 34'd37) % HASH_MOD;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- src/cphtk_hash.sv -----
// ----------------------------------------------------------------------------
// cphtk_hash
// Home slot of a 22-character key: weighted powers of 37 reduced by one
// shared shift-subtract unit, first mod 100003 per used character (all but
// character 11), then mod the table size.
// ----------------------------------------------------------------------------
`default_nettype none

module cphtk_hash #(
   parameter int TABLE_SIZE = 8191
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [175:0]                  key_bits,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      home
);

   localparam int SW = $clog2(TABLE_SIZE);
   localparam cphtk_pkg::pow_tab_type POW = cphtk_pkg::pow37_table();

   cphtk_pkg::hash_state_type hst_ff, hst_in;
   logic [4:0]                        j_ff, j_in;
   logic signed [23:0]                sum_ff, sum_in;
   logic [cphtk_pkg::RED_W-1:0]       red_ff, red_in;
   logic [4:0]                        sh_ff, sh_in;
   logic                              neg_ff, neg_in;
   logic                              fin_ff, fin_in;
   logic [SW-1:0]                     home_ff, home_in;
   logic                              done_ff, done_in;

   logic [4:0]                        jr;
   logic [175:0]                      shifted;
   logic [7:0]                        ch;
   logic [4:0]                        pidx;
   logic                              low;
   logic [7:0]                        cmag;
   logic [cphtk_pkg::RED_W-1:0]       prod;
   logic [cphtk_pkg::MOD_W-1:0]       mod_w;
   logic [45:0]                       dvs;
   logic signed [23:0]                term;

   always_comb begin
      jr      = 5'd21 - j_ff;
      shifted = key_bits >> {jr, 3'b000};
      ch      = shifted[7:0];
      pidx    = (j_ff < 5'd12) ? 5'd20 - j_ff : 5'd21 - j_ff;
      low     = j_ff < 5'd4;
      cmag    = low ? ((ch >= 8'd55) ? ch - 8'd55 : 8'd55 - ch) : ch;
      prod    = cphtk_pkg::RED_W'(cmag * POW[pidx]);
      mod_w   = fin_ff ? cphtk_pkg::MOD_W'(TABLE_SIZE) : cphtk_pkg::MOD_W'(cphtk_pkg::HASH_MOD);
      dvs     = 46'(mod_w) << sh_ff;
      term    = neg_ff ? -24'(red_ff) : 24'(red_ff);
   end

   always_comb begin
      hst_in  = hst_ff;
      j_in    = j_ff;
      sum_in  = sum_ff;
      red_in  = red_ff;
      sh_in   = sh_ff;
      neg_in  = neg_ff;
      fin_in  = fin_ff;
      home_in = home_ff;
      done_in = 1'b0;
      unique case (hst_ff)
         cphtk_pkg::H_IDLE: begin
            if (start) begin
               j_in   = 5'd0;
               sum_in = '0;
               hst_in = cphtk_pkg::H_MUL;
            end
         end
         cphtk_pkg::H_MUL: begin
            red_in = prod;
            neg_in = low && (ch < 8'd55);
            sh_in  = 5'(cphtk_pkg::SHIFT_TOP);
            fin_in = 1'b0;
            hst_in = cphtk_pkg::H_RED;
         end
         cphtk_pkg::H_RED: begin
            if (46'(red_ff) >= dvs) begin
               red_in = red_ff - dvs[cphtk_pkg::RED_W-1:0];
            end
            sh_in = sh_ff - 5'd1;
            if (sh_ff == 5'd0) begin
               hst_in = fin_ff ? cphtk_pkg::H_DONE : cphtk_pkg::H_ACC;
            end
         end
         cphtk_pkg::H_ACC: begin
            sum_in = sum_ff + term;
            j_in   = (j_ff == 5'd10) ? 5'd12 : j_ff + 5'd1;
            hst_in = (j_ff == 5'd21) ? cphtk_pkg::H_FMAG : cphtk_pkg::H_MUL;
         end
         cphtk_pkg::H_FMAG: begin
            red_in = sum_ff[23] ? cphtk_pkg::RED_W'(-sum_ff) : cphtk_pkg::RED_W'(sum_ff);
            neg_in = sum_ff[23];
            sh_in  = 5'(cphtk_pkg::SHIFT_TOP);
            fin_in = 1'b1;
            hst_in = cphtk_pkg::H_RED;
         end
         cphtk_pkg::H_DONE: begin
            home_in = (neg_ff && red_ff != '0) ?
                      SW'(cphtk_pkg::RED_W'(TABLE_SIZE) - red_ff) : SW'(red_ff);
            done_in = 1'b1;
            hst_in  = cphtk_pkg::H_IDLE;
         end
         default: hst_in = cphtk_pkg::H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hst_ff  <= cphtk_pkg::H_IDLE;
         done_ff <= 1'b0;
      end else begin
         hst_ff  <= hst_in;
         done_ff <= done_in;
      end
      j_ff    <= j_in;
      sum_ff  <= sum_in;
      red_ff  <= red_in;
      sh_ff   <= sh_in;
      neg_ff  <= neg_in;
      fin_ff  <= fin_in;
      home_ff <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

`default_nettype wire

// ----- src/cubic_probe_hash_table_topk_core.sv -----
// ----------------------------------------------------------------------------
// cubic_probe_hash_table_topk_core
// Account table with cubic open-addressing probes, saturating balances and a
// sorted balance list for largest-first top-k queries.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   req_     | in        | req_valid/req_stall | cphtk_pkg::req_type
//   rsp_     | out       | rsp_valid/rsp_stall | cphtk_pkg::rsp_type
//
// One request at a time. Hash: on the shared shift-subtract reducer. Probe
// scan: one slot read per cycle, up to TABLE_SIZE slots. List update: a read
// and a check state per list entry moved or inspected. Top-k: read, fetch and
// response states per result, plus output stalls. After reset a clearing pass
// over every slot empties the slot table before the first request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_probe_hash_table_topk_core #(
   parameter int TABLE_SIZE = 8191,
   parameter int MAX_K      = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire cphtk_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output cphtk_pkg::rsp_type      rsp_data
);

   localparam int SW = $clog2(TABLE_SIZE);
   localparam int CW = cphtk_pkg::CNT_W;
   localparam logic [SW:0] TSZ = (SW+1)'(TABLE_SIZE);

   cphtk_pkg::state_type state_ff, state_in;
   cphtk_pkg::req_type   req_ff, req_in;

   logic [SW-1:0]        clr_ff, clr_in;
   logic [SW:0]          i_ff, i_in;
   logic [SW-1:0]        cu_ff, cu_in, d_ff, d_in, e_ff, e_in;
   logic                 pv_ff, pv_in;
   logic [SW-1:0]        pa_ff, pa_in;
   logic                 mf_ff, mf_in, ff_ff, ff_in;
   logic [SW-1:0]        ms_ff, ms_in, fs_ff, fs_in;
   logic signed [31:0]   mb_ff, mb_in;
   logic signed [31:0]   vold_ff, vold_in, vnew_ff, vnew_in;
   logic                 nadd_ff, nadd_in;
   logic [CW-1:0]        q_ff, q_in;
   logic                 lf_ff, lf_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [6:0]           t_ff, t_in, k_ff, k_in;
   logic [1:0]           rst_ff, rst_in;
   logic                 rfd_ff, rfd_in, rlast_ff, rlast_in;
   logic signed [31:0]   rbal_ff, rbal_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cphtk_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                 used_mem [0:TABLE_SIZE-1];
   cphtk_pkg::slot_type  ent_mem  [0:TABLE_SIZE-1];
   logic signed [31:0]   lst_mem  [0:cphtk_pkg::MAX_ENTRIES-1];
   logic                 used_rd_ff;
   cphtk_pkg::slot_type  ent_rd_ff;
   logic signed [31:0]   lst_rd_ff;

   logic                 used_we, used_wd, ent_we, lst_we;
   logic [SW-1:0]        used_wa, ent_wa, mem_ra;
   cphtk_pkg::slot_type  ent_wd;
   logic [CW-1:0]        lst_wa, lst_ra;
   logic signed [31:0]   lst_wd;

   logic                 hash_start, hash_done;
   logic [SW-1:0]        home;

   logic [SW:0]          asum, cusum, dsum, esum;
   logic [SW-1:0]        addr, cu_nx, d_nx, e_nx;
   logic                 key_eq, hit, stop;
   logic signed [32:0]   wide;
   logic signed [31:0]   satv;
   logic [6:0]           kb, kc;
   logic                 take;

   cphtk_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key_bits ({req_ff.key_bytes_0_7, req_ff.key_bytes_8_15, req_ff.key_bytes_16_21}),
      .done     (hash_done),
      .home     (home)
   );

   always_comb begin
      asum  = {1'b0, home} + {1'b0, cu_ff};
      addr  = (asum >= TSZ) ? SW'(asum - TSZ) : SW'(asum);
      cusum = {1'b0, cu_ff} + {1'b0, d_ff};
      cu_nx = (cusum >= TSZ) ? SW'(cusum - TSZ) : SW'(cusum);
      dsum  = {1'b0, d_ff} + {1'b0, e_ff};
      d_nx  = (dsum >= TSZ) ? SW'(dsum - TSZ) : SW'(dsum);
      esum  = {1'b0, e_ff} + (SW+1)'(6);
      e_nx  = (esum >= TSZ) ? SW'(esum - TSZ) : SW'(esum);
      key_eq = ent_rd_ff.key0 == req_ff.key_bytes_0_7 &&
               ent_rd_ff.key1 == req_ff.key_bytes_8_15 &&
               ent_rd_ff.key2 == req_ff.key_bytes_16_21;
      hit  = pv_ff && used_rd_ff && key_eq;
      wide = 33'(mb_ff) + 33'(req_ff.amount);
      satv = (wide[32] != wide[31]) ? (wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                    : wide[31:0];
      kb = (req_ff.top_k_count == 7'd0) ? 7'd1 : req_ff.top_k_count;
      if (kb > 7'(MAX_K)) begin
         kb = 7'(MAX_K);
      end
      kc = (CW'(kb) > cnt_ff) ? cnt_ff[6:0] : kb;
      take = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      clr_in     = clr_ff;
      i_in       = i_ff;
      cu_in      = cu_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      pv_in      = pv_ff;
      pa_in      = pa_ff;
      mf_in      = mf_ff;
      ff_in      = ff_ff;
      ms_in      = ms_ff;
      fs_in      = fs_ff;
      mb_in      = mb_ff;
      vold_in    = vold_ff;
      vnew_in    = vnew_ff;
      nadd_in    = nadd_ff;
      q_in       = q_ff;
      lf_in      = lf_ff;
      cnt_in     = cnt_ff;
      t_in       = t_ff;
      k_in       = k_ff;
      rst_in     = rst_ff;
      rfd_in     = rfd_ff;
      rbal_in    = rbal_ff;
      rlast_in   = rlast_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      hash_start = 1'b0;
      stop       = 1'b0;
      used_we    = 1'b0;
      used_wa    = clr_ff;
      used_wd    = 1'b0;
      ent_we     = 1'b0;
      ent_wa     = fs_ff;
      ent_wd     = '{key0: req_ff.key_bytes_0_7, key1: req_ff.key_bytes_8_15,
                     key2: req_ff.key_bytes_16_21, bal: req_ff.amount};
      mem_ra     = addr;
      lst_we     = 1'b0;
      lst_wa     = q_ff;
      lst_wd     = vnew_ff;
      lst_ra     = q_ff;
      unique case (state_ff)
         cphtk_pkg::S_CLEAR: begin
            used_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SW'(TABLE_SIZE - 1)) begin
               state_in = cphtk_pkg::S_IDLE;
            end
         end
         cphtk_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = cphtk_pkg::S_DISPATCH;
            end
         end
         cphtk_pkg::S_DISPATCH: begin
            rlast_in = 1'b1;
            rfd_in   = 1'b0;
            rbal_in  = '0;
            rst_in   = cphtk_pkg::ST_OK;
            case (req_ff.kind)
               cphtk_pkg::KIND_INSERT, cphtk_pkg::KIND_LOOKUP,
               cphtk_pkg::KIND_ADD, cphtk_pkg::KIND_DELETE: begin
                  hash_start = 1'b1;
                  state_in   = cphtk_pkg::S_HASH;
               end
               cphtk_pkg::KIND_TOPK: begin
                  t_in = '0;
                  k_in = kc;
                  if (cnt_ff == '0) begin
                     rst_in   = cphtk_pkg::ST_EMPTY;
                     state_in = cphtk_pkg::S_RESP;
                  end else begin
                     state_in = cphtk_pkg::S_TK_RD;
                  end
               end
               default: state_in = cphtk_pkg::S_RESP;
            endcase
         end
         cphtk_pkg::S_HASH: begin
            i_in  = '0;
            cu_in = '0;
            d_in  = SW'(1);
            e_in  = SW'(6);
            pv_in = 1'b0;
            mf_in = 1'b0;
            ff_in = 1'b0;
            if (hash_done) begin
               state_in = cphtk_pkg::S_PROBE;
            end
         end
         cphtk_pkg::S_PROBE: begin
            if (hit && !mf_ff) begin
               mf_in = 1'b1;
               ms_in = pa_ff;
               mb_in = ent_rd_ff.bal;
            end
            if (pv_ff && !used_rd_ff && !ff_ff) begin
               ff_in = 1'b1;
               fs_in = pa_ff;
            end
            stop = (req_ff.kind == cphtk_pkg::KIND_INSERT) ? ff_in : mf_in;
            if (stop || (i_ff == TSZ && !pv_ff)) begin
               pv_in    = 1'b0;
               state_in = cphtk_pkg::S_DECIDE;
            end else if (i_ff != TSZ) begin
               pv_in = 1'b1;
               pa_in = addr;
               i_in  = i_ff + 1'b1;
               cu_in = cu_nx;
               d_in  = d_nx;
               e_in  = e_nx;
            end else begin
               pv_in = 1'b0;
            end
         end
         cphtk_pkg::S_DECIDE: begin
            state_in = cphtk_pkg::S_RESP;
            if (req_ff.kind == cphtk_pkg::KIND_LOOKUP ||
                req_ff.kind == cphtk_pkg::KIND_DELETE ||
                (req_ff.kind == cphtk_pkg::KIND_ADD && mf_ff)) begin
               if (!mf_ff) begin
                  rst_in = cphtk_pkg::ST_NOTFOUND;
               end else begin
                  rfd_in  = 1'b1;
                  vold_in = mb_ff;
                  q_in    = '0;
                  lf_in   = 1'b0;
                  if (req_ff.kind == cphtk_pkg::KIND_LOOKUP) begin
                     rbal_in = mb_ff;
                  end else if (req_ff.kind == cphtk_pkg::KIND_DELETE) begin
                     rbal_in  = mb_ff;
                     used_we  = 1'b1;
                     used_wa  = ms_ff;
                     nadd_in  = 1'b0;
                     state_in = cphtk_pkg::S_LREM_RD;
                  end else begin
                     rbal_in    = satv;
                     vnew_in    = satv;
                     ent_we     = 1'b1;
                     ent_wa     = ms_ff;
                     ent_wd.bal = satv;
                     nadd_in    = 1'b1;
                     state_in   = cphtk_pkg::S_LREM_RD;
                  end
               end
            end else if (cnt_ff >= CW'(cphtk_pkg::MAX_ENTRIES) || !ff_ff) begin
               rst_in = cphtk_pkg::ST_FULL;
            end else begin
               used_we  = 1'b1;
               used_wa  = fs_ff;
               used_wd  = 1'b1;
               ent_we   = 1'b1;
               rbal_in  = req_ff.amount;
               vnew_in  = req_ff.amount;
               q_in     = cnt_ff;
               state_in = cphtk_pkg::S_LADD_RD;
            end
         end
         cphtk_pkg::S_LREM_RD: begin
            if (q_ff == cnt_ff) begin
               cnt_in   = lf_ff ? cnt_ff - 1'b1 : cnt_ff;
               q_in     = cnt_in;
               state_in = nadd_ff ? cphtk_pkg::S_LADD_RD : cphtk_pkg::S_RESP;
            end else begin
               state_in = cphtk_pkg::S_LREM_CHK;
            end
         end
         cphtk_pkg::S_LREM_CHK: begin
            if (!lf_ff) begin
               lf_in = lst_rd_ff == vold_ff;
            end else begin
               lst_we = 1'b1;
               lst_wa = q_ff - 1'b1;
               lst_wd = lst_rd_ff;
            end
            q_in     = q_ff + 1'b1;
            state_in = cphtk_pkg::S_LREM_RD;
         end
         cphtk_pkg::S_LADD_RD: begin
            lst_ra = q_ff - 1'b1;
            if (q_ff == '0) begin
               lst_we   = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = cphtk_pkg::S_RESP;
            end else begin
               state_in = cphtk_pkg::S_LADD_CHK;
            end
         end
         cphtk_pkg::S_LADD_CHK: begin
            lst_we = 1'b1;
            if (lst_rd_ff < vnew_ff) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = cphtk_pkg::S_RESP;
            end else begin
               lst_wd   = lst_rd_ff;
               q_in     = q_ff - 1'b1;
               state_in = cphtk_pkg::S_LADD_RD;
            end
         end
         cphtk_pkg::S_TK_RD: begin
            lst_ra   = cnt_ff - 1'b1 - CW'(t_ff);
            state_in = cphtk_pkg::S_TK_GET;
         end
         cphtk_pkg::S_TK_GET: begin
            rbal_in  = lst_rd_ff;
            rlast_in = (t_ff + 7'd1) == k_ff;
            state_in = cphtk_pkg::S_RESP;
         end
         cphtk_pkg::S_RESP: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: rst_ff, found: rfd_ff, balance: rbal_ff,
                                entry_count: cnt_ff, last: rlast_ff};
               if (req_ff.kind == cphtk_pkg::KIND_TOPK && !rlast_ff) begin
                  t_in     = t_ff + 7'd1;
                  state_in = cphtk_pkg::S_TK_RD;
               end else begin
                  state_in = cphtk_pkg::S_IDLE;
               end
            end
         end
         default: state_in = cphtk_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_rd_ff <= used_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      ent_rd_ff <= ent_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (lst_we) begin
         lst_mem[lst_wa] <= lst_wd;
      end
      lst_rd_ff <= lst_mem[lst_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cphtk_pkg::S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      i_ff        <= i_in;
      cu_ff       <= cu_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      pa_ff       <= pa_in;
      mf_ff       <= mf_in;
      ff_ff       <= ff_in;
      ms_ff       <= ms_in;
      fs_ff       <= fs_in;
      mb_ff       <= mb_in;
      vold_ff     <= vold_in;
      vnew_ff     <= vnew_in;
      nadd_ff     <= nadd_in;
      q_ff        <= q_in;
      lf_ff       <= lf_in;
      t_ff        <= t_in;
      k_ff        <= k_in;
      rst_ff      <= rst_in;
      rfd_ff      <= rfd_in;
      rbal_ff     <= rbal_in;
      rlast_ff    <= rlast_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != cphtk_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/cphtk_checker.sv -----
// ----------------------------------------------------------------------------
// cphtk_checker
// Port-level checks of the cubic-probe account table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cphtk_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire cphtk_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire cphtk_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == req_data.kind |=> req_stall)
      else $error("second request taken while busy");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == cphtk_pkg::ST_EMPTY |->
         rsp_data.last && rsp_data.entry_count == '0 && rsp_data.balance == '0)
      else $error("bad no-entries response");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cphtk_pkg::ST_NOTFOUND ||
                    rsp_data.status == cphtk_pkg::ST_FULL) |->
         !rsp_data.found && rsp_data.balance == '0 && rsp_data.last)
      else $error("bad miss or full response");

endmodule

bind cubic_probe_hash_table_topk_core cphtk_checker u_cphtk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- dv/tb_cubic_probe_hash_table_topk_core.sv -----
// ----------------------------------------------------------------------------
// tb_cubic_probe_hash_table_topk_core
// Self-checking bench for the cubic-probe account table. A directed table
// covers empty-table answers, unused kinds, saturation, duplicate keys and the
// top-k count limits. It is followed by random requests over a small pool of
// keys, so that hits, updates and deletes happen often. A behavioral model
// predicts each response not fixed by a directed row. Both sides idle and
// stall at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cubic_probe_hash_table_topk_core;

   localparam int TS      = 8191;
   localparam int TOPK_MX = 64;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;

   typedef struct {
      cphtk_pkg::req_type rq;
      bit                 typed;
      cphtk_pkg::rsp_type want;
   } row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   cphtk_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   cphtk_pkg::rsp_type rsp_data;

   bit                 used_slot [TS];
   logic [63:0]        slot_k0 [TS];
   logic [63:0]        slot_k1 [TS];
   logic [47:0]        slot_k2 [TS];
   longint             slot_bal [TS];
   longint             ranked_bal [$];
   cphtk_pkg::rsp_type pending_answers [$];
   row_type            rows [$];
   cphtk_pkg::req_type key_pool [$];
   int                 errors;
   bit                 steady;
   bit                 hold_req;
   int                 hold_left;

   cubic_probe_hash_table_topk_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void append_rsp(ref cphtk_pkg::rsp_type q [$],
                                      input cphtk_pkg::rsp_type a);
      q = {q, a};
   endfunction

   function automatic longint pow37(int p);
      longint r;
      r = 1;
      for (int t = 0; t < p; t++) r = (r * 37) % cphtk_pkg::HASH_MOD;
      return r;
   endfunction

   function automatic int home_of(cphtk_pkg::req_type r);
      logic [175:0] kb;
      longint sum, c;
      kb = {r.key_bytes_0_7, r.key_bytes_8_15, r.key_bytes_16_21};
      sum = 0;
      for (int j = 0; j < 22; j++) begin
         c = longint'(kb[175 - 8*j -: 8]);
         if (j < 4) sum += ((c - 55) * pow37(20 - j)) % cphtk_pkg::HASH_MOD;
         else if (j < 11) sum += (c * pow37(16 - (j - 4))) % cphtk_pkg::HASH_MOD;
         else if (j >= 12) sum += (c * pow37(9 - (j - 12))) % cphtk_pkg::HASH_MOD;
      end
      sum = sum % TS;
      if (sum < 0) sum += TS;
      return int'(sum);
   endfunction

   function automatic int probe_of(int home, longint i);
      return int'((longint'(home) + ((i * i) % TS) * i % TS) % TS);
   endfunction

   function automatic int locate_key(cphtk_pkg::req_type r);
      int home, s;
      home = home_of(r);
      for (int i = 0; i < TS; i++) begin
         s = probe_of(home, i);
         if (used_slot[s] && slot_k0[s] == r.key_bytes_0_7 &&
             slot_k1[s] == r.key_bytes_8_15 && slot_k2[s] == r.key_bytes_16_21)
            return s;
      end
      return -1;
   endfunction

   function automatic void rank_add(longint v);
      int p;
      p = 0;
      while (p < ranked_bal.size() && ranked_bal[p] < v) p++;
      ranked_bal.insert(p, v);
   endfunction

   function automatic void rank_remove(longint v);
      for (int p = 0; p < ranked_bal.size(); p++)
         if (ranked_bal[p] == v) begin
            ranked_bal.delete(p);
            return;
         end
   endfunction

   function automatic logic [1:0] store_key(cphtk_pkg::req_type r, longint v);
      int home, s;
      if (ranked_bal.size() >= cphtk_pkg::MAX_ENTRIES) return cphtk_pkg::ST_FULL;
      home = home_of(r);
      for (int i = 0; i < TS; i++) begin
         s = probe_of(home, i);
         if (!used_slot[s]) begin
            used_slot[s] = 1'b1;
            slot_k0[s]   = r.key_bytes_0_7;
            slot_k1[s]   = r.key_bytes_8_15;
            slot_k2[s]   = r.key_bytes_16_21;
            slot_bal[s]  = v;
            rank_add(v);
            return cphtk_pkg::ST_OK;
         end
      end
      return cphtk_pkg::ST_FULL;
   endfunction

   function automatic cphtk_pkg::rsp_type answer(logic [1:0] st, logic fnd, longint v,
                                                 logic lst);
      cphtk_pkg::rsp_type a;
      a.status      = st;
      a.found       = fnd;
      a.balance     = v[31:0];
      a.entry_count = 13'(ranked_bal.size());
      a.last        = lst;
      return a;
   endfunction

   function automatic void apply_account_op(cphtk_pkg::req_type r,
                                            ref cphtk_pkg::rsp_type outs [$]);
      int s, k, n;
      longint amt, v;
      logic [1:0] st;
      amt = longint'(r.amount);
      outs = {};
      case (r.kind)
         cphtk_pkg::KIND_INSERT: begin
            st = store_key(r, amt);
            append_rsp(outs, answer(st, 1'b0, st == cphtk_pkg::ST_OK ? amt : 0, 1'b1));
         end
         cphtk_pkg::KIND_LOOKUP, cphtk_pkg::KIND_DELETE, cphtk_pkg::KIND_ADD: begin
            s = locate_key(r);
            if (s < 0 && r.kind == cphtk_pkg::KIND_ADD) begin
               st = store_key(r, amt);
               append_rsp(outs, answer(st, 1'b0, st == cphtk_pkg::ST_OK ? amt : 0, 1'b1));
            end else if (s < 0) begin
               append_rsp(outs, answer(cphtk_pkg::ST_NOTFOUND, 1'b0, 0, 1'b1));
            end else if (r.kind == cphtk_pkg::KIND_LOOKUP) begin
               append_rsp(outs, answer(cphtk_pkg::ST_OK, 1'b1, slot_bal[s], 1'b1));
            end else if (r.kind == cphtk_pkg::KIND_ADD) begin
               v = slot_bal[s] + amt;
               if (v > SMAX) v = SMAX;
               if (v < SMIN) v = SMIN;
               rank_remove(slot_bal[s]);
               slot_bal[s] = v;
               rank_add(v);
               append_rsp(outs, answer(cphtk_pkg::ST_OK, 1'b1, v, 1'b1));
            end else begin
               v = slot_bal[s];
               rank_remove(v);
               used_slot[s] = 1'b0;
               slot_bal[s] = 0;
               append_rsp(outs, answer(cphtk_pkg::ST_OK, 1'b1, v, 1'b1));
            end
         end
         cphtk_pkg::KIND_TOPK: begin
            n = ranked_bal.size();
            if (n == 0) append_rsp(outs, answer(cphtk_pkg::ST_EMPTY, 1'b0, 0, 1'b1));
            else begin
               k = (r.top_k_count == 0) ? 1 : r.top_k_count;
               if (k > TOPK_MX) k = TOPK_MX;
               if (k > n) k = n;
               for (int t = 0; t < k; t++)
                  append_rsp(outs, answer(cphtk_pkg::ST_OK, 1'b0, ranked_bal[n - 1 - t],
                                          t + 1 == k));
            end
         end
         default: append_rsp(outs, answer(cphtk_pkg::ST_OK, 1'b0, 0, 1'b1));
      endcase
   endfunction

   function automatic cphtk_pkg::req_type make_req(logic [2:0] kd, cphtk_pkg::req_type key,
                                                   longint amt, int k);
      cphtk_pkg::req_type r;
      r = key;
      r.kind = kd;
      r.amount = amt[31:0];
      r.top_k_count = k[6:0];
      return r;
   endfunction

   function automatic void add_row(cphtk_pkg::req_type r, bit typed, logic [1:0] st,
                                   int cnt);
      row_type w;
      w.rq = r;
      w.typed = typed;
      w.want = '{status: st, found: 1'b0, balance: 32'sd0, entry_count: cnt[12:0],
                 last: 1'b1};
      rows = {rows, w};
   endfunction

   function automatic cphtk_pkg::req_type rand_key();
      cphtk_pkg::req_type r;
      r = '0;
      r.key_bytes_0_7   = {$urandom, $urandom};
      r.key_bytes_8_15  = {$urandom, $urandom};
      r.key_bytes_16_21 = 48'({$urandom, $urandom});
      return r;
   endfunction

   task automatic send(cphtk_pkg::req_type r, bit typed, cphtk_pkg::rsp_type want);
      cphtk_pkg::rsp_type outs [$];
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      apply_account_op(r, outs);
      if (typed) append_rsp(pending_answers, want);
      else foreach (outs[i]) append_rsp(pending_answers, outs[i]);
      @(negedge clock);
   endtask

   initial begin
      bit hold_fired;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      hold_fired = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_fired) begin
            hold_left  = 25000;
            hold_fired = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else rsp_stall <= !steady && $urandom_range(0, 99) < 15;
      end
   end

   always @(posedge clock) begin
      cphtk_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("response with nothing pending");
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.found !== e.found) begin
               $error("found expected %0d actual %0d", e.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.balance !== e.balance) begin
               $error("balance expected %0d actual %0d", e.balance, rsp_data.balance);
               errors++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $error("entry_count expected %0d actual %0d", e.entry_count,
                      rsp_data.entry_count);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   initial begin
      #60000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      cphtk_pkg::req_type ka, kb, kc, kz, kf, r;
      cphtk_pkg::rsp_type none;
      int wait_cnt;
      errors    = 0;
      steady    = 1'b0;
      hold_req  = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      none      = '0;
      ka = '0;
      ka.key_bytes_0_7 = "ALICE_AC"; ka.key_bytes_8_15 = "COUNT_00";
      ka.key_bytes_16_21 = "0001XY";
      kb = ka; kb.key_bytes_16_21 = "0002ZZ";
      kc = ka; kc.key_bytes_0_7 = "!!!~~~  ";
      kz = '0;
      kf = '1; kf.kind = '0; kf.amount = '0; kf.top_k_count = '0;
      add_row(make_req(cphtk_pkg::KIND_TOPK, ka, 0, 3), 1, cphtk_pkg::ST_EMPTY, 0);
      add_row(make_req(cphtk_pkg::KIND_LOOKUP, ka, 0, 0), 1, cphtk_pkg::ST_NOTFOUND, 0);
      add_row(make_req(cphtk_pkg::KIND_DELETE, kb, 0, 0), 1, cphtk_pkg::ST_NOTFOUND, 0);
      add_row(make_req(3'd5, kf, -1, 127), 1, cphtk_pkg::ST_OK, 0);
      add_row(make_req(3'd6, ka, 5, 1), 1, cphtk_pkg::ST_OK, 0);
      add_row(make_req(3'd7, kz, 0, 0), 1, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_INSERT, ka, SMAX, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_INSERT, kb, SMIN, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_INSERT, ka, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_ADD, ka, 1, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_ADD, kb, -1, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_ADD, kc, 77, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_LOOKUP, ka, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_TOPK, ka, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_TOPK, ka, 0, 127), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_TOPK, ka, 0, 64), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_DELETE, ka, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_LOOKUP, ka, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_INSERT, kf, -5, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_INSERT, kz, 9, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_ADD, kf, SMIN, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_DELETE, kb, 0, 0), 0, cphtk_pkg::ST_OK, 0);
      add_row(make_req(cphtk_pkg::KIND_TOPK, ka, 0, 2), 0, cphtk_pkg::ST_OK, 0);
      key_pool = '{ka, kb, kc, kz, kf};
      for (int i = 0; i < 6; i++) key_pool = {key_pool, rand_key()};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].want);

      for (int n = 0; n < 100; n++) begin
         int sel;
         hold_req = (n == 10);
         steady   = (n >= 40 && n < 70);
         r = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                          : rand_key();
         sel = $urandom_range(0, 19);
         r.kind = (sel < 5) ? cphtk_pkg::KIND_INSERT : (sel < 9) ? cphtk_pkg::KIND_LOOKUP :
                  (sel < 14) ? cphtk_pkg::KIND_ADD : (sel < 17) ? cphtk_pkg::KIND_DELETE :
                  (sel < 19) ? cphtk_pkg::KIND_TOPK : 3'($urandom_range(5, 7));
         r.amount = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 1000;
         r.top_k_count = 7'($urandom_range(0, 127));
         send(r, 0, none);
      end
      hold_req = 1'b0;
      steady   = 1'b0;
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      wait_cnt = 0;
      while (wait_cnt < 20000) begin
         @(posedge clock);
         wait_cnt++;
      end
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/cphtk_pkg.sv
src/cphtk_hash.sv
src/cubic_probe_hash_table_topk_core.sv
src/cphtk_checker.sv
dv/tb_cubic_probe_hash_table_topk_core.sv
